// File: rtl/core/ascii_sci_number_parser_macros.svh
// assertion macros for the ascii scientific number parser
// used by the top level only; needs clk and rst in the including scope
`ifndef ASCII_SCI_NUMBER_PARSER_MACROS_SVH
`define ASCII_SCI_NUMBER_PARSER_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASNP_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("asnp check failed");

// condition must hold in the cycle after the trigger
`define ASNP_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("asnp check failed");

`endif

// File: rtl/core/asnp_pkg.sv
// types and constants for the ascii scientific number parser
// no dependencies
package asnp_pkg;

  localparam int MAX_DIGITS = 18;
  localparam int EXP_LIMIT  = 999;

  localparam logic [1:0] PH_INT  = 2'd0;
  localparam logic [1:0] PH_FRAC = 2'd1;
  localparam logic [1:0] PH_EXP  = 2'd2;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef struct packed {
    logic [1:0]  phase;
    logic        sign_neg;
    logic        exp_neg;
    logic [59:0] digit_acc;
    logic [4:0]  digit_count;
    logic [4:0]  frac_count;
    logic [9:0]  exp_acc;
    logic        ovf_flag;
  } asnp_state_t;

  typedef struct packed {
    logic               overflow;
    logic signed [10:0] exponent;
    logic [4:0]         fraction_digits;
    logic [59:0]        significand;
    logic               negative;
  } asnp_result_t;

  localparam asnp_state_t STATE_RESET = '{
    phase: PH_INT, sign_neg: 1'b0, exp_neg: 1'b0, digit_acc: 60'd0,
    digit_count: 5'd0, frac_count: 5'd0, exp_acc: 10'd0, ovf_flag: 1'b0
  };

endpackage

// File: rtl/core/asnp_step.sv
// per-character parse step: next parser state and the result for a final character
// depends on asnp_pkg
module asnp_step (
  input  asnp_pkg::asnp_state_t  cur,
  input  logic [7:0]             char_code,
  output asnp_pkg::asnp_state_t  nxt,
  output asnp_pkg::asnp_result_t result
);
  import asnp_pkg::*;

  logic        is_digit;
  logic [3:0]  digit;
  logic        lead_zero;
  logic        room;
  logic [59:0] acc_times_ten;
  logic [13:0] exp_v;
  logic [9:0]  exp_mag;

  assign is_digit = char_code inside {[CH_ZERO:CH_NINE]};
  assign digit    = char_code[3:0];
  assign lead_zero = (cur.phase == PH_INT) && (cur.digit_acc == 60'd0) && (digit == 4'd0);
  assign room      = cur.digit_count < 5'(MAX_DIGITS);
  assign acc_times_ten = {cur.digit_acc[56:0], 3'b000} + {cur.digit_acc[58:0], 1'b0}
                         + {56'd0, digit};
  assign exp_v = {1'b0, cur.exp_acc, 3'b000} + {3'b000, cur.exp_acc, 1'b0} + {10'd0, digit};

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_INT: begin
        if (char_code == CH_PLUS) begin
          nxt.sign_neg = 1'b0;
        end else if (char_code == CH_MINUS) begin
          nxt.sign_neg = 1'b1;
        end else if (is_digit) begin
          if (!lead_zero) begin
            if (room) begin
              nxt.digit_acc   = acc_times_ten;
              nxt.digit_count = cur.digit_count + 5'd1;
            end else begin
              nxt.ovf_flag = 1'b1;
            end
          end
        end else if (char_code == CH_DOT) begin
          nxt.phase = PH_FRAC;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (room) begin
            nxt.digit_acc   = acc_times_ten;
            nxt.digit_count = cur.digit_count + 5'd1;
            nxt.frac_count  = cur.frac_count + 5'd1;
          end else begin
            nxt.ovf_flag = 1'b1;
          end
        end else if (char_code inside {CH_UPPER_E, CH_LOWER_E}) begin
          nxt.phase = PH_EXP;
        end
      end
      default: begin
        // exponent phase
        if (char_code == CH_PLUS) begin
          nxt.exp_neg = 1'b0;
        end else if (char_code == CH_MINUS) begin
          nxt.exp_neg = 1'b1;
        end else if (is_digit) begin
          if (exp_v > 14'(EXP_LIMIT)) begin
            nxt.exp_acc  = 10'(EXP_LIMIT);
            nxt.ovf_flag = 1'b1;
          end else begin
            nxt.exp_acc = exp_v[9:0];
          end
        end
      end
    endcase
  end

  assign exp_mag = nxt.exp_acc;

  always_comb begin
    result.negative        = nxt.sign_neg;
    result.significand     = nxt.digit_acc;
    result.fraction_digits = nxt.frac_count;
    result.exponent        = nxt.exp_neg ? -$signed({1'b0, exp_mag})
                                         : $signed({1'b0, exp_mag});
    result.overflow        = nxt.ovf_flag;
  end

endmodule

// File: rtl/core/ascii_sci_number_parser.sv
// ascii scientific number parser, one character per transaction on the input stream
// a final character passes the input register, then the result register behind m_tvalid
// throughput: one character per cycle with a multiply-by-ten-and-add step, except that
// a final character waits in the input register while the previous result is unaccepted
// rst is synchronous: clears both registers' valid flags and returns the parser to
// the integer phase with empty accumulators
`include "ascii_sci_number_parser_macros.svh"
module ascii_sci_number_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // [0] negative, [60:1] significand,
                                 // [65:61] fraction_digits, [76:66] exponent,
                                 // [77] overflow, [79:78] zero
);
  import asnp_pkg::*;

  logic         in_valid;
  logic [7:0]   in_char;
  logic         in_last;
  logic         out_free;
  logic         fire;
  asnp_state_t  st;
  asnp_state_t  st_next;
  asnp_result_t step_result;
  asnp_result_t res;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || fire;

  asnp_step u_step (
    .cur       (st),
    .char_code (in_char),
    .nxt       (st_next),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (fire) begin
      st <= in_last ? STATE_RESET : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      res <= step_result;
    end
  end

  assign m_tdata = {2'b00, res.overflow, res.exponent, res.fraction_digits,
                    res.significand, res.negative};

  `ASNP_ASSERT_NEXT(a_result_after_final, fire && in_last, m_tvalid)
  `ASNP_ASSERT_NEXT(a_cleared_after_final, fire && in_last,
                    st.phase == PH_INT && st.digit_count == 5'd0 && st.exp_acc == 10'd0)
  `ASNP_ASSERT_NOW(a_digit_bounds, 1'b1,
                   st.digit_count <= 5'(MAX_DIGITS) && st.frac_count <= st.digit_count)
  `ASNP_ASSERT_NOW(a_exp_bound, 1'b1, st.exp_acc <= 10'(EXP_LIMIT))

endmodule

// File: tb/asnp_reading_checker.sv
`timescale 1ns / 1ps
// watches both streams of the ascii scientific number parser, predicts each reading
// and compares it field by field with what comes out; needs asnp_pkg
module asnp_reading_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // [0] negative, [60:1] significand, [65:61] fraction_digits,
                                 // [76:66] exponent, [77] overflow, [79:78] zero
  input  logic        run_done,
  output int          errors,
  output int          pending,
  output int          chars_parsed,
  output int          readings_checked,
  output int          overflow_readings
);
  import asnp_pkg::*;

  // parser state as the predictor sees it
  logic [1:0]  ph          = PH_INT;
  logic        mant_neg    = 1'b0;
  logic        exp_minus   = 1'b0;
  logic [59:0] mant_acc    = '0;
  logic [4:0]  mant_digits = '0;
  logic [4:0]  frac_digits = '0;
  logic [9:0]  exp_mag     = '0;
  logic        ovf         = 1'b0;

  asnp_result_t expected_readings[$];
  int fail_count = 0;
  bit leftovers_checked = 1'b0;

  initial begin
    chars_parsed = 0;
    readings_checked = 0;
    overflow_readings = 0;
    pending = 0;
  end

  assign errors = fail_count;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic bit take_mantissa_digit(input logic [3:0] d);
    // leading integer zeros leave the accumulator alone and are not counted
    if (ph == PH_INT && mant_acc == 60'd0 && d == 4'd0) return 1'b1;
    if (mant_digits >= MAX_DIGITS) begin
      ovf = 1'b1;
      return 1'b0;
    end
    mant_acc = mant_acc * 60'd10 + 60'(d);
    mant_digits++;
    return 1'b1;
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic fin);
    logic [3:0] d;
    bit is_dig;
    int v;
    asnp_result_t want;
    d = 4'(c - CH_ZERO);
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    case (ph)
      PH_INT: begin
        if (c == CH_PLUS) mant_neg = 1'b0;
        else if (c == CH_MINUS) mant_neg = 1'b1;
        else if (is_dig) void'(take_mantissa_digit(d));
        else if (c == CH_DOT) ph = PH_FRAC;
      end
      PH_FRAC: begin
        if (is_dig) begin
          if (take_mantissa_digit(d)) frac_digits++;
        end else if (c == CH_UPPER_E || c == CH_LOWER_E) begin
          ph = PH_EXP;
        end
      end
      default: begin
        if (c == CH_PLUS) exp_minus = 1'b0;
        else if (c == CH_MINUS) exp_minus = 1'b1;
        else if (is_dig) begin
          v = int'(exp_mag) * 10 + int'(d);
          if (v > EXP_LIMIT) begin
            v = EXP_LIMIT;
            ovf = 1'b1;
          end
          exp_mag = v[9:0];
        end
      end
    endcase
    if (fin) begin
      want.negative        = mant_neg;
      want.significand     = mant_acc;
      want.fraction_digits = frac_digits;
      want.exponent        = exp_minus ? -11'(exp_mag) : 11'(exp_mag);
      want.overflow        = ovf;
      expected_readings.push_back(want);
      ph          = PH_INT;
      mant_neg    = 1'b0;
      exp_minus   = 1'b0;
      mant_acc    = '0;
      mant_digits = '0;
      frac_digits = '0;
      exp_mag     = '0;
      ovf         = 1'b0;
    end
  endtask

  task automatic check_reading(input logic [79:0] data);
    asnp_result_t got;
    asnp_result_t want;
    got = data[77:0];
    if (expected_readings.size() == 0) begin
      report_mismatch("reading with none outstanding, significand", got.significand, 0);
      return;
    end
    want = expected_readings.pop_front();
    readings_checked++;
    if (want.overflow) overflow_readings++;
    if (got.negative !== want.negative)
      report_mismatch("negative", got.negative, want.negative);
    if (got.significand !== want.significand)
      report_mismatch("significand", got.significand, want.significand);
    if (got.fraction_digits !== want.fraction_digits)
      report_mismatch("fraction_digits", got.fraction_digits, want.fraction_digits);
    if (got.exponent !== want.exponent)
      report_mismatch("exponent", got.exponent, want.exponent);
    if (got.overflow !== want.overflow)
      report_mismatch("overflow", got.overflow, want.overflow);
    if (data[79:78] !== 2'b00)
      report_mismatch("tdata padding", data[79:78], 0);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_reading(m_tdata);
      if (s_tvalid && s_tready) begin
        chars_parsed++;
        parse_char(s_tdata, s_tlast);
      end
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_readings.size() != 0)
          report_mismatch("readings never returned", expected_readings.size(), 0);
      end
    end
  end

  // published away from the rising edge so the stimulus side reads a settled count
  always @(negedge clk) pending <= expected_readings.size();

endmodule

// File: tb/tb_ascii_sci_number_parser.sv
`timescale 1ns / 1ps
// top of the ascii scientific number parser testbench: clock, reset, character stimulus,
// output back-pressure and the verdict; needs asnp_pkg and asnp_reading_checker
module tb_ascii_sci_number_parser;
  import asnp_pkg::*;

  localparam int RANDOM_PER_PHASE = 350;
  localparam int HOLD_CYCLES      = 500;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 20;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = '0;   // [7:0] char_code
  logic        s_tlast  = 1'b0; // last_char
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [79:0] m_tdata;         // [0] negative, [60:1] significand, [65:61] fraction_digits,
                                // [76:66] exponent, [77] overflow, [79:78] zero
  logic        run_done     = 1'b0;
  logic        hold_request = 1'b0;

  int hold_left     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int chars_sent    = 0;
  int idle_cycles   = 0;
  int errors, pending, chars_parsed, readings_checked, overflow_readings;

  always #2 clk = ~clk;

  ascii_sci_number_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  asnp_reading_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .s_tlast           (s_tlast),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .run_done          (run_done),
    .errors            (errors),
    .pending           (pending),
    .chars_parsed      (chars_parsed),
    .readings_checked  (readings_checked),
    .overflow_readings (overflow_readings)
  );

  // result side: random stalls, or one long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string text, input bit ends);
    for (int i = 0; i < text.len(); i++)
      send_char(text[i], ends && (i == text.len() - 1));
  endtask

  // stop offering and wait for every outstanding reading
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // mostly well-formed readings with random digits; some noise and broken ones
  task automatic send_random_reading();
    byte unsigned chars[$];
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(1, 12);
      repeat (n) chars.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(3))
        1: chars.push_back(CH_PLUS);
        2: chars.push_back(CH_MINUS);
        3: repeat (2) chars.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) chars.push_back(CH_ZERO);
      n = ($urandom_range(7) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 6);
      repeat (n) chars.push_back(8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(9) < 8) begin
        chars.push_back(CH_DOT);
        n = ($urandom_range(7) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
        repeat (n) chars.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(9) < 6) begin
          chars.push_back($urandom_range(1) ? CH_UPPER_E : CH_LOWER_E);
          repeat ($urandom_range(2)) chars.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
          n = ($urandom_range(9) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 3);
          repeat (n) chars.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
      end else if ($urandom_range(1) == 0) begin
        // exponent marker before any dot is just ignored
        chars.push_back(CH_UPPER_E);
        repeat ($urandom_range(1, 3)) chars.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      if (kind < 25 && chars.size() > 0)
        chars.insert($urandom_range(chars.size() - 1), 8'($urandom_range(255)));
    end
    if (chars.size() == 0) chars.push_back(8'($urandom_range(255)));
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic run_random(input int n_chars);
    int target;
    target = chars_sent + n_chars;
    while (chars_sent < target) send_random_reading();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    recv_idle_pct = 84;
    // signs, leading zeros, digits past the limit, minus zero exponent
    send_text("-001234567890123456789.5e-0", 1'b1);
    send_text("+-7E2", 1'b1);
    send_text(".e1000", 1'b1);
    // no digits at all, top code and a nul on the final character
    send_text("+", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    run_random(RANDOM_PER_PHASE);
    wait_drained();

    send_idle_pct = 84;
    recv_idle_pct = 15;
    run_random(RANDOM_PER_PHASE / 2);
    wait_drained();
    run_random(RANDOM_PER_PHASE / 2);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_PER_PHASE / 2);
    // keep offering short readings while the output is held off
    hold_request <= 1'b1;
    repeat (30) begin
      send_char(8'(CH_ZERO + $urandom_range(9)), 1'b0);
      send_char(8'(CH_ZERO + $urandom_range(9)), 1'b1);
    end
    run_random(RANDOM_PER_PHASE / 2 - 60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (3) @(posedge clk);

    $display("parsed %0d characters into %0d checked readings, %0d of them with overflow",
             chars_parsed, readings_checked, overflow_readings);
    $display("back-pressure on both sides, one long output hold-off and a full drain pause");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
